### rtl/core/accel_tilt_angles_fixed_point_defines.svh
// Assertion macros shared by the tilt angle modules.
`ifndef ACCEL_TILT_ANGLES_FIXED_POINT_DEFINES_SVH
`define ACCEL_TILT_ANGLES_FIXED_POINT_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define ATA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define ATA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ata_pkg.sv
`timescale 1ns / 1ps
package ata_pkg;
  localparam int InW   = 16;
  localparam int PitchW = 15;
  localparam int RollW  = 16;
  // Angle constants in radians x 10000.
  localparam logic signed [17:0] HalfPi    = 18'sd15708;
  localparam logic signed [17:0] Pi        = 18'sd31416;
  localparam logic [12:0]        QuarterPi = 13'd7854;
  localparam logic [11:0]        Slope     = 12'd2730;
  localparam logic [13:0]        Unit      = 14'd10000;
  localparam logic [26:0]        RecipNum  = 27'd100000000;
  localparam logic [12:0]        DegScale  = 13'd5729;
endpackage

### rtl/core/accel_tilt_angles_fixed_point.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     start, busy            in_accel_x, in_accel_y, in_accel_z
// result    out_valid (one cycle)  out_pitch_centideg, out_roll_centideg
// One transaction keeps busy high through a square root, then per angle up to
// five passes through the shared 29-bit serial divider (ratio, reciprocal, two
// polynomial steps, scaling).
// busy is high from the accepting edge until the result strobe.
// Reset clears the sequencer; the result ports then hold no valid data.
// The receiver cannot stall; each result is shown for exactly one cycle.
module accel_tilt_angles_fixed_point (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [ata_pkg::InW-1:0]    in_accel_x,
  input  logic signed [ata_pkg::InW-1:0]    in_accel_y,
  input  logic signed [ata_pkg::InW-1:0]    in_accel_z,
  output logic                         out_valid,
  output logic signed [ata_pkg::PitchW-1:0] out_pitch_centideg,
  output logic signed [ata_pkg::RollW-1:0]  out_roll_centideg
);
  import ata_pkg::*;
  `include "accel_tilt_angles_fixed_point_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_SETUP, S_RATIO, S_RECIP, S_POLY, S_ANGLE,
    S_DEG, S_NEXT, S_OUT
  } state_t;

  state_t state_r;
  logic signed [16:0] y_r, x_r;        // current atan2 operands
  logic signed [15:0] ay_r, az_r;
  logic               second_r;        // 0: pitch, 1: roll
  logic [31:0]        sq_r;
  logic               sq_ph_r;
  logic               neg_r, flip_r;
  logic [27:0]        m_r;
  logic signed [18:0] ang_r;
  logic [1:0]         ph_r;
  logic signed [PitchW-1:0] pitch_r;
  logic signed [RollW-1:0]  roll_r;
  logic               valid_r;

  // Shared divider.
  logic        dv_start, dv_done, sr_start, sr_done;
  logic [28:0] dv_a, dv_b, dv_q;
  logic [15:0] root;

  ata_sqrt u_sqrt (.clk, .rst_n, .start(sr_start), .radicand(sq_r),
                   .done(sr_done), .root(root));
  ata_div u_div (.clk, .rst_n, .start(dv_start), .dividend(dv_a),
                 .divisor(dv_b), .done(dv_done), .quotient(dv_q));

  // Magnitudes of the operands.
  logic [16:0] ymag, xmag;
  logic [16:0] absy, absz;
  logic [29:0] prod;
  logic signed [32:0] degp;
  logic [13:0] mm;
  assign ymag = y_r[16] ? 17'(-y_r) : 17'(y_r);
  assign xmag = x_r[16] ? 17'(-x_r) : 17'(x_r);
  assign absy = ay_r[15] ? 17'(-{ay_r[15], ay_r}) : {1'b0, ay_r};
  assign absz = az_r[15] ? 17'(-{az_r[15], az_r}) : {1'b0, az_r};
  assign mm   = m_r[13:0];
  // Poly steps: slope term, then product; both single multipliers.
  assign prod = (ph_r == 2'd0) ? 30'(Slope) * (30'(Unit) - 30'(mm))
                               : 30'(mm) * (30'(QuarterPi) + 30'(m_r[27:14]));
  assign degp = 33'(ang_r) * 33'(signed'({1'b0, DegScale}));

  always_comb begin
    sr_start = (state_r == S_SQRT) && sq_ph_r;
    dv_start = 1'b0;
    dv_a = '0;
    dv_b = 29'd1;
    unique case (state_r)
      S_SETUP: begin
        dv_start = (x_r != '0);
        dv_a = 29'(ymag) * 29'(Unit);
        dv_b = 29'(xmag);
      end
      S_RATIO: begin
        dv_start = dv_done && (dv_q > 29'(Unit));
        dv_a = 29'(RecipNum);
        dv_b = dv_q;
      end
      S_POLY: begin
        dv_start = (ph_r == 2'd0) || (ph_r == 2'd2);
        dv_a = 29'(prod);
        dv_b = 29'(Unit);
      end
      S_DEG: begin
        dv_start = (ph_r == 2'd0);
        dv_a = degp[32] ? 29'(-degp) : 29'(degp);
        dv_b = 29'(Unit);
      end
      default: ;
    endcase
  end

  // Sequencer and its registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      ph_r    <= '0;
      sq_ph_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          y_r <= 17'(in_accel_x);
          ay_r <= in_accel_y;
          az_r <= in_accel_z;
          second_r <= 1'b0;
          sq_ph_r <= 1'b0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          // Squares of y and z, one per cycle.
          if (!sq_ph_r) begin
            sq_r <= 32'(absy) * 32'(absy);
            sq_ph_r <= 1'b1;
          end else begin
            sq_r <= sq_r + 32'(absz) * 32'(absz);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          // The root is started once, in the first cycle of this state.
          sq_ph_r <= 1'b0;
          if (sr_done) begin
            x_r <= {1'b0, root};
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          neg_r <= (y_r[16] != x_r[16]) && (y_r != '0);
          flip_r <= 1'b0;
          ph_r <= '0;
          if (x_r == '0) begin
            ang_r <= y_r[16] ? 19'(-HalfPi) : (y_r == '0 ? '0 : 19'(HalfPi));
            state_r <= S_DEG;
          end else state_r <= S_RATIO;
        end
        S_RATIO: if (dv_done) begin
          if (dv_q > 29'(Unit)) begin
            flip_r <= 1'b1;
            state_r <= S_RECIP;
          end else begin
            m_r <= 28'(dv_q);
            state_r <= S_POLY;
          end
        end
        S_RECIP: if (dv_done) begin
          m_r <= 28'(dv_q);
          state_r <= S_POLY;
        end
        S_POLY: begin
          unique case (ph_r)
            2'd0: ph_r <= 2'd1;
            2'd1: if (dv_done) begin
              m_r[27:14] <= dv_q[13:0];
              ph_r <= 2'd2;
            end
            2'd2: ph_r <= 2'd3;
            default: if (dv_done) begin
              ang_r <= 19'(dv_q[15:0]);
              ph_r <= '0;
              state_r <= S_ANGLE;
            end
          endcase
        end
        S_ANGLE: begin
          // Reflect, apply sign, then move into the left half plane.
          logic signed [18:0] a;
          a = flip_r ? 19'(HalfPi) - ang_r : ang_r;
          a = neg_r ? -a : a;
          if (x_r[16]) a = y_r[16] ? a - 19'(Pi) : a + 19'(Pi);
          ang_r <= a;
          ph_r <= '0;
          state_r <= S_DEG;
        end
        S_DEG: begin
          if (ph_r == 2'd0) ph_r <= 2'd1;
          else if (dv_done) begin
            if (!second_r)
              pitch_r <= PitchW'(ang_r[18] ? -$signed({1'b0, dv_q[15:0]})
                                            : $signed({1'b0, dv_q[15:0]}));
            else
              roll_r <= RollW'(ang_r[18] ? -$signed({1'b0, dv_q[15:0]})
                                          : $signed({1'b0, dv_q[15:0]}));
            state_r <= second_r ? S_OUT : S_NEXT;
          end
        end
        S_NEXT: begin
          second_r <= 1'b1;
          y_r <= 17'(ay_r);
          x_r <= 17'(az_r);
          state_r <= S_SETUP;
        end
        S_OUT: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_pitch_centideg = pitch_r;
  assign out_roll_centideg = roll_r;

  `ATA_ASSERT_NXT(a_accept, clk, rst_n, start && !busy, busy, "transaction not taken")
  `ATA_ASSERT_IMP(a_valid_idle, clk, rst_n, valid_r, state_r == S_IDLE, "strobe while busy")
  `ATA_ASSERT_NXT(a_one_strobe, clk, rst_n, valid_r, !valid_r, "strobe held")
endmodule

### rtl/core/ata_sqrt.sv
`timescale 1ns / 1ps
// Bit-serial floor square root: two radicand bits per cycle.
module ata_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        done,
  output logic [15:0] root
);
  import ata_pkg::*;
  `include "accel_tilt_angles_fixed_point_defines.svh"

  logic [31:0] rad_r, rad_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [17:0] shifted, trial;

  // One restoring step per cycle.
  always_comb begin
    shifted  = {rem_r[15:0], rad_r[31:30]};
    trial    = {root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[29:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

  `ATA_ASSERT_NXT(a_sqrt_start, clk, rst_n, start, busy_r, "sqrt did not start")
  `ATA_ASSERT_IMP(a_sqrt_done, clk, rst_n, done_r, !busy_r, "sqrt done while busy")
  `ATA_ASSERT_IMP(a_sqrt_cnt, clk, rst_n, busy_r, cnt_r != 5'd0, "sqrt count lost")
endmodule

### rtl/core/ata_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module ata_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [28:0] dividend,
  input  logic [28:0] divisor,
  output logic        done,
  output logic [28:0] quotient
);
  import ata_pkg::*;
  `include "accel_tilt_angles_fixed_point_defines.svh"

  logic [28:0] quo_r, quo_nxt, dsr_r, dsr_nxt;
  logic [29:0] rem_r, rem_nxt, sh;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  // Shift in one dividend bit and try a subtract each cycle.
  always_comb begin
    sh       = {rem_r[28:0], quo_r[28]};
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = 5'd29;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, dsr_r}) begin
        rem_nxt = sh - {1'b0, dsr_r};
        quo_nxt = {quo_r[27:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[27:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  `ATA_ASSERT_NXT(a_div_start, clk, rst_n, start, busy_r, "divider did not start")
  `ATA_ASSERT_IMP(a_div_done, clk, rst_n, done_r, !busy_r, "divider done while busy")
  `ATA_ASSERT_IMP(a_div_cnt, clk, rst_n, busy_r, cnt_r != 5'd0, "divider count lost")
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ata_pkg::*;

  typedef struct {
    logic signed [PitchW-1:0] pitch;
    logic signed [RollW-1:0]  roll;
  } tilt_t;

  // Integer square root, rounded down.
  function automatic longint isqrt(longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Quadratic approximation of the arctangent of a ratio scaled by 10000.
  function automatic longint atan_ratio(longint q);
    longint m;
    longint a;
    bit flip;
    m = (q < 0) ? -q : q;
    flip = 0;
    if (m > 10000) begin
      m = 100000000 / m;
      flip = 1;
    end
    a = (m * (7854 + (2730 * (10000 - m)) / 10000)) / 10000;
    if (flip) a = 15708 - a;
    return (q < 0) ? -a : a;
  endfunction

  // Four-quadrant angle in radians x 10000.
  function automatic longint angle(longint y, longint x);
    longint a;
    if (x == 0) return (y > 0) ? 15708 : ((y < 0) ? -15708 : 0);
    a = atan_ratio((y * 10000) / x);
    if (x > 0) return a;
    return (y >= 0) ? a + 31416 : a - 31416;
  endfunction

  function automatic tilt_t predict_tilt(longint ax, longint ay, longint az);
    tilt_t t;
    longint run;
    run = isqrt(ay * ay + az * az);
    t.pitch = PitchW'((angle(ax, run) * 5729) / 10000);
    t.roll = RollW'((angle(ay, az) * 5729) / 10000);
    return t;
  endfunction

  // Holds the predicted angles and checks each result against the oldest.
  class tilt_board;
    tilt_t pending[$];
    int errors;

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
      pending.push_back(predict_tilt(ax, ay, az));
    endfunction

    function void check_angles(logic signed [PitchW-1:0] p,
                               logic signed [RollW-1:0] r);
      tilt_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pitch %0d roll %0d", p, r);
        return;
      end
      e = pending.pop_front();
      if (e.pitch !== p || e.roll !== r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pitch %0d roll %0d, got pitch %0d roll %0d",
                   e.pitch, e.roll, p, r);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [InW-1:0] in_accel_x;
  logic signed [InW-1:0] in_accel_y;
  logic signed [InW-1:0] in_accel_z;
  logic out_valid;
  logic signed [PitchW-1:0] out_pitch_centideg;
  logic signed [RollW-1:0] out_roll_centideg;
  tilt_board board;

  accel_tilt_angles_fixed_point dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every strobed result is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_angles(out_pitch_centideg, out_roll_centideg);
  end

  // Random gap: mostly short, occasionally long, never empty.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) n = 1;
    repeat (n) @(posedge clk);
  endtask

  // Presents one sample and waits for the transaction to be accepted.
  task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az);
    start <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    do @(posedge clk); while (busy);
    board.note_sample(ax, ay, az);
    start <= 1'b0;
    idle_gap();
  endtask

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 20)) - 10);
      3: return 16'(int'($urandom_range(0, 2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int v;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    board = new();
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_accel_x = '0;
    in_accel_y = '0;
    in_accel_z = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: zero vector, axis extremes, zero runs, all quadrants, ratio edges.
    send_sample(0, 0, 0);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
    send_sample(32767, 0, 0);
    send_sample(-32768, 0, 0);
    send_sample(0, 100, 0);
    send_sample(0, -100, 0);
    send_sample(0, 0, -5);
    send_sample(0, 5, -5);
    send_sample(0, -5, -5);
    send_sample(0, 5, 5);
    send_sample(0, -5, 5);
    send_sample(100, 100, 0);
    send_sample(-100, 0, 100);
    send_sample(1, 32767, -32768);
    send_sample(-32768, 1, 32767);
    send_sample(7, -32768, 1);
    send_sample(1, 1, -32768);
    send_sample(16'h5555, 16'h2aaa, 16'hd555);
    send_sample(16'haaaa, 16'hd555, 16'h2aaa);
    // Let the pipeline drain completely once before random traffic.
    while (board.pending.size() != 0) @(posedge clk);
    for (v = 0; v < 850; v++) begin
      a = rand_axis();
      b = rand_axis();
      c = rand_axis();
      send_sample(a, b, c);
      if (v == 400) while (board.pending.size() != 0) @(posedge clk);
    end
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #400ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
